@@ hw/rtl/stt_pkg.sv @@
// Package: token kinds, scanner modes, payload types and character class helpers.
`default_nettype none
package stt_pkg;

  localparam int unsigned MaxCommentDepth = 15;
  localparam int unsigned PositionBits    = 16;
  localparam int unsigned LenBits         = 16;

  typedef enum logic [5:0] {
    M_IDLE   = 6'd0,  M_IDENT  = 6'd1,  M_ZERO   = 6'd2,
    M_PRE_B  = 6'd3,  M_PRE_C  = 6'd4,  M_PRE_D  = 6'd5,  M_PRE_X  = 6'd6,
    M_NUM_B  = 6'd7,  M_NUM_C  = 6'd8,  M_NUM_D  = 6'd9,  M_NUM_X  = 6'd10,
    M_LINE   = 6'd11, M_BLOCK  = 6'd12, M_TILDE  = 6'd13, M_EXCLM  = 6'd14,
    M_QUEST  = 6'd15, M_AMPER  = 6'd16, M_PIPE   = 6'd17, M_CARET  = 6'd18,
    M_EQUAL  = 6'd19, M_LESS   = 6'd20, M_LESS2  = 6'd21, M_GREAT  = 6'd22,
    M_GREAT2 = 6'd23, M_PLUS   = 6'd24, M_MINUS  = 6'd25, M_STAR   = 6'd26,
    M_SLASH  = 6'd27, M_PERC   = 6'd28, M_DOT    = 6'd29, M_DOT2   = 6'd30,
    M_COLON  = 6'd31, M_SEMIC  = 6'd32, M_HASH   = 6'd33
  } mode_e;

  localparam logic [6:0] K_EOF     = 7'd0;
  localparam logic [6:0] K_INVALID = 7'd1;
  localparam logic [6:0] K_IDENT   = 7'd2;
  localparam logic [6:0] K_INTEGER = 7'd3;
  localparam logic [6:0] K_COMMENT = 7'd4;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_STAR  = 2'd1;
  localparam logic [1:0] PEND_SLASH = 2'd2;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [4:0]  radix;
    logic [15:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;
  } out_word_t;

  // Up to two tokens produced by a single character.
  typedef struct packed {
    logic      first_vld;
    out_word_t first;
    logic      second_vld;
    out_word_t second;
  } tok_pair_t;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] radix_of(input logic [1:0] idx);
    case (idx)
      2'd0:    return 5'd2;
      2'd1:    return 5'd8;
      2'd2:    return 5'd10;
      default: return 5'd16;
    endcase
  endfunction

  function automatic logic digit_ok(input logic [1:0] idx, input logic [7:0] c);
    if (c == "_") return 1'b1;
    case (idx)
      2'd0:    return c == "0" || c == "1";
      2'd1:    return c >= "0" && c <= "7";
      2'd2:    return is_dig(c);
      default: return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endcase
  endfunction

  function automatic logic [6:0] short_kind(input mode_e m);
    case (m)
      M_TILDE:  return 7'd12;
      M_EXCLM:  return 7'd15;
      M_QUEST:  return 7'd19;
      M_AMPER:  return 7'd22;
      M_PIPE:   return 7'd25;
      M_CARET:  return 7'd27;
      M_EQUAL:  return 7'd30;
      M_LESS:   return 7'd35;
      M_LESS2:  return 7'd33;
      M_GREAT:  return 7'd39;
      M_GREAT2: return 7'd38;
      M_PLUS:   return 7'd42;
      M_MINUS:  return 7'd46;
      M_STAR:   return 7'd49;
      M_SLASH:  return 7'd51;
      M_PERC:   return 7'd53;
      M_DOT:    return 7'd56;
      M_DOT2:   return 7'd55;
      M_COLON:  return 7'd59;
      M_SEMIC:  return 7'd61;
      M_HASH:   return 7'd64;
      default:  return K_INVALID;
    endcase
  endfunction

  function automatic mode_e punct_mode(input logic [7:0] c);
    case (c)
      "~":     return M_TILDE;
      "!":     return M_EXCLM;
      "?":     return M_QUEST;
      "&":     return M_AMPER;
      "|":     return M_PIPE;
      "^":     return M_CARET;
      "=":     return M_EQUAL;
      "<":     return M_LESS;
      ">":     return M_GREAT;
      "+":     return M_PLUS;
      "-":     return M_MINUS;
      "*":     return M_STAR;
      "/":     return M_SLASH;
      "%":     return M_PERC;
      ".":     return M_DOT;
      ":":     return M_COLON;
      ";":     return M_SEMIC;
      "#":     return M_HASH;
      default: return M_IDLE;
    endcase
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] c);
    case (c)
      "(":     return 7'd5;
      ")":     return 7'd6;
      "[":     return 7'd7;
      "]":     return 7'd8;
      "{":     return 7'd9;
      "}":     return 7'd10;
      ",":     return 7'd62;
      "@":     return 7'd65;
      default: return K_INVALID;
    endcase
  endfunction

  // Two-character extension: kind of the finished token (0 for none).
  function automatic logic [6:0] ext_kind(input mode_e m, input logic [7:0] c);
    case (m)
      M_TILDE:  return c == "=" ? 7'd11 : 7'd0;
      M_EXCLM:  return c == "=" ? 7'd13 : (c == "!" ? 7'd14 : 7'd0);
      M_QUEST:  return c == "=" ? 7'd16 : (c == "?" ? 7'd17 : (c == "." ? 7'd18 : 7'd0));
      M_AMPER:  return c == "=" ? 7'd20 : (c == "&" ? 7'd21 : 7'd0);
      M_PIPE:   return c == "=" ? 7'd23 : (c == "|" ? 7'd24 : 7'd0);
      M_CARET:  return c == "=" ? 7'd26 : 7'd0;
      M_EQUAL:  return c == "=" ? 7'd28 : (c == ">" ? 7'd29 : 7'd0);
      M_LESS:   return c == "=" ? 7'd31 : (c == "-" ? 7'd34 : 7'd0);
      M_LESS2:  return c == "=" ? 7'd32 : 7'd0;
      M_GREAT:  return c == "=" ? 7'd36 : 7'd0;
      M_GREAT2: return c == "=" ? 7'd37 : 7'd0;
      M_PLUS:   return c == "=" ? 7'd40 : (c == "+" ? 7'd41 : 7'd0);
      M_MINUS:  return c == "=" ? 7'd43 : (c == "-" ? 7'd44 : (c == ">" ? 7'd45 : 7'd0));
      M_STAR:   return c == "=" ? 7'd47 : (c == "*" ? 7'd48 : 7'd0);
      M_SLASH:  return c == "=" ? 7'd50 : 7'd0;
      M_PERC:   return c == "=" ? 7'd52 : 7'd0;
      M_DOT2:   return c == "." ? 7'd54 : 7'd0;
      M_COLON:  return c == "=" ? 7'd57 : (c == ":" ? 7'd58 : 7'd0);
      M_SEMIC:  return c == ";" ? 7'd60 : 7'd0;
      M_HASH:   return c == "#" ? 7'd63 : 7'd0;
      default:  return 7'd0;
    endcase
  endfunction

  // Extension that moves to another mode rather than finishing.
  function automatic mode_e ext_go(input mode_e m, input logic [7:0] c);
    case (m)
      M_LESS:  return c == "<" ? M_LESS2 : M_IDLE;
      M_GREAT: return c == ">" ? M_GREAT2 : M_IDLE;
      M_SLASH: return c == "/" ? M_LINE : (c == "*" ? M_BLOCK : M_IDLE);
      M_DOT:   return c == "." ? M_DOT2 : M_IDLE;
      default: return M_IDLE;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/source_text_tokenizer.sv @@
// Top level: streaming maximal-munch source tokenizer.
// Output: each token is written into the output queue and leaves from its registers.
// Throughput: one character word per cycle while the queue has room for two tokens;
//   a word may yield two tokens, and the four-entry output queue absorbs such bursts.
// Reset: rst_ni clears scanner mode, lexeme length and queue; line and column
//   return to one.
`default_nettype none
module source_text_tokenizer #(
  parameter int unsigned MaxCommentDepth = stt_pkg::MaxCommentDepth,
  parameter int unsigned PositionBits    = stt_pkg::PositionBits
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  stt_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output stt_pkg::out_word_t  out_data_o
);
  import stt_pkg::*;

  logic      step;
  logic      space;
  tok_pair_t toks;

  // Accept a word whenever the queue can take both possible tokens.
  assign in_ready_o = space;
  assign step       = in_valid_i && in_ready_o;

  stt_scan #(
    .MaxDepth (MaxCommentDepth),
    .PosBits  (PositionBits)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_data_i),
    .toks_o (toks)
  );

  stt_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .toks_i  (toks),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_eof_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind == K_EOF |-> out_data_o.last_of_run)
    else $error("eof token not last");
  a_eof_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind == K_EOF |-> out_data_o.token_length == '0)
    else $error("eof token with length");
  a_eoi_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_data_i.end_of_input |=> out_valid_o) else $error("end of input lost");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/stt_scan.sv @@
// Scanner core: per-character state transition and token build.
`default_nettype none
module stt_scan #(
  parameter int unsigned MaxDepth = stt_pkg::MaxCommentDepth,
  parameter int unsigned PosBits  = stt_pkg::PositionBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  stt_pkg::in_word_t      word_i,
  output stt_pkg::tok_pair_t     toks_o
);
  import stt_pkg::*;

  localparam int unsigned DepthBits = $clog2(MaxDepth + 1);
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [DepthBits-1:0] DepthMax = DepthBits'(MaxDepth);

  mode_e                mode_q, mode_d;
  logic [DepthBits-1:0] depth_q, depth_d;
  logic [1:0]           pend_q, pend_d;
  logic [LenBits-1:0]   len_q, len_d;
  logic [PosBits-1:0]   line_q, line_d, col_q, col_d, tline_q, tline_d, tcol_q, tcol_d;

  logic [LenBits-1:0] len_inc;
  logic [7:0]         c, lc;
  logic               eoi;
  logic [6:0]         ek;
  mode_e              eg;
  logic               cont;
  logic               fl_vld, st_vld;
  logic [6:0]         fl_kind, st_kind;
  logic [4:0]         fl_radix;
  logic [LenBits-1:0] fl_len;

  always_comb begin
    c       = word_i.character;
    eoi     = word_i.end_of_input;
    lc      = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    len_inc = (len_q == {LenBits{1'b1}}) ? len_q : len_q + LenBits'(1);
    ek      = ext_kind(mode_q, c);
    eg      = ext_go(mode_q, c);
  end

  // Flush kind of the token pending in the current mode.
  always_comb begin
    fl_vld   = 1'b1;
    fl_radix = 5'd0;
    fl_kind  = K_INVALID;
    case (mode_q)
      M_IDLE:  fl_vld = 1'b0;
      M_IDENT: fl_kind = K_IDENT;
      M_ZERO: begin
        fl_kind  = K_INTEGER;
        fl_radix = 5'd10;
      end
      M_PRE_B, M_PRE_C, M_PRE_D, M_PRE_X: fl_kind = K_INVALID;
      M_NUM_B, M_NUM_C, M_NUM_D, M_NUM_X: begin
        fl_kind  = K_INTEGER;
        fl_radix = radix_of(2'(mode_q - M_NUM_B));
      end
      M_LINE, M_BLOCK: fl_kind = K_COMMENT;
      default: fl_kind = short_kind(mode_q);
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    depth_d  = depth_q;
    pend_d   = pend_q;
    len_d    = len_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    line_d   = line_q;
    col_d    = col_q;
    toks_o   = '0;
    cont     = 1'b0;
    fl_len   = len_q;
    st_vld   = 1'b0;
    st_kind  = K_INVALID;

    if (eoi) begin
      toks_o.first_vld  = fl_vld;
      toks_o.first      = '{fl_kind, fl_radix, len_q, 16'(tline_q), 16'(tcol_q), 1'b0};
      toks_o.second_vld = 1'b1;
      toks_o.second     = '{K_EOF, 5'd0, 16'd0, 16'(line_q), 16'(col_q), 1'b0};
      mode_d  = M_IDLE;
      depth_d = '0;
      pend_d  = PEND_NONE;
      len_d   = '0;
    end else begin
      // Continue the current token where the character allows it.
      case (mode_q)
        M_IDLE: ;
        M_IDENT: if (is_alpha(c) || is_dig(c) || c == "_") begin
          cont  = 1'b1;
          len_d = len_inc;
        end
        M_ZERO: begin
          if (lc == "b" || lc == "c" || lc == "d" || lc == "x") begin
            cont   = 1'b1;
            len_d  = len_inc;
            mode_d = lc == "b" ? M_PRE_B : lc == "c" ? M_PRE_C :
                     lc == "d" ? M_PRE_D : M_PRE_X;
          end else if (is_dig(c) || c == "_") begin
            cont   = 1'b1;
            len_d  = len_inc;
            mode_d = M_NUM_D;
          end
        end
        M_PRE_B, M_PRE_C, M_PRE_D, M_PRE_X,
        M_NUM_B, M_NUM_C, M_NUM_D, M_NUM_X: begin
          if (digit_ok(2'(mode_q - M_PRE_B), c)) begin
            cont   = 1'b1;
            len_d  = len_inc;
            mode_d = mode_e'(6'(M_NUM_B) + 6'(2'(mode_q - M_PRE_B)));
          end
        end
        M_LINE: begin
          cont  = 1'b1;
          len_d = len_inc;
          if (c == 8'd10) begin
            toks_o.first_vld = 1'b1;
            toks_o.first     = '{K_COMMENT, 5'd0, len_inc, 16'(tline_q), 16'(tcol_q), 1'b0};
            mode_d = M_IDLE;
            len_d  = '0;
          end
        end
        M_BLOCK: begin
          cont  = 1'b1;
          len_d = len_inc;
          if (pend_q == PEND_STAR && c == "/") begin
            pend_d = PEND_NONE;
            if (depth_q <= DepthBits'(1)) begin
              toks_o.first_vld = 1'b1;
              toks_o.first     = '{K_COMMENT, 5'd0, len_inc, 16'(tline_q), 16'(tcol_q), 1'b0};
              mode_d  = M_IDLE;
              depth_d = '0;
              len_d   = '0;
            end else begin
              depth_d = depth_q - DepthBits'(1);
            end
          end else if (pend_q == PEND_SLASH && c == "*") begin
            pend_d = PEND_NONE;
            if (depth_q < DepthMax) depth_d = depth_q + DepthBits'(1);
          end else begin
            pend_d = c == "*" ? PEND_STAR : (c == "/" ? PEND_SLASH : PEND_NONE);
          end
        end
        default: begin
          if (eg != M_IDLE) begin
            cont   = 1'b1;
            len_d  = len_inc;
            mode_d = eg;
            if (eg == M_BLOCK) begin
              depth_d = DepthBits'(1);
              pend_d  = PEND_NONE;
            end
          end else if (ek != 7'd0) begin
            cont             = 1'b1;
            toks_o.first_vld = 1'b1;
            toks_o.first     = '{ek, 5'd0, len_inc, 16'(tline_q), 16'(tcol_q), 1'b0};
            mode_d = M_IDLE;
            len_d  = '0;
          end
        end
      endcase

      if (!cont) begin
        // Flush the pending token, then start a new one with this character unless it is white space.
        toks_o.first_vld = fl_vld;
        toks_o.first     = '{fl_kind, fl_radix, fl_len, 16'(tline_q), 16'(tcol_q), 1'b0};
        mode_d  = M_IDLE;
        depth_d = '0;
        pend_d  = PEND_NONE;
        len_d   = '0;
        if (!is_space(c)) begin
          tline_d  = line_q;
          tcol_d   = col_q;
          len_d    = LenBits'(1);
          if (c == "0") mode_d = M_ZERO;
          else if (is_dig(c)) mode_d = M_NUM_D;
          else if (is_alpha(c) || c == "_" || c == "$") mode_d = M_IDENT;
          else if (punct_mode(c) != M_IDLE) mode_d = punct_mode(c);
          else begin
            st_vld  = 1'b1;
            st_kind = single_kind(c);
            mode_d  = M_IDLE;
            len_d   = '0;
          end
        end
        toks_o.second_vld = st_vld;
        toks_o.second     = '{st_kind, 5'd0, 16'd1, 16'(line_q), 16'(col_q), 1'b0};
      end

      if (c == 8'd10) begin
        if (line_q != PosMax) line_d = line_q + PosBits'(1);
        col_d = PosBits'(1);
      end else if (col_q != PosMax) begin
        col_d = col_q + PosBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      depth_q <= '0;
      pend_q  <= PEND_NONE;
      len_q   <= '0;
      line_q  <= PosBits'(1);
      col_q   <= PosBits'(1);
      tline_q <= PosBits'(1);
      tcol_q  <= PosBits'(1);
    end else if (step_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != M_BLOCK |-> depth_q == '0) else $error("comment depth left set");
  a_block_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_BLOCK |-> depth_q != '0) else $error("block comment at depth zero");
  a_idle_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_IDLE |-> len_q == '0) else $error("idle with lexeme length");
  a_line_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0 && col_q != '0) else $error("position reached zero");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/stt_outq.sv @@
// Output queue: holds up to four token words and drains them one per cycle while ready_i is high.
`default_nettype none
module stt_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  stt_pkg::tok_pair_t   toks_i,
  output logic                 space_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output stt_pkg::out_word_t   word_o
);
  import stt_pkg::*;

  out_word_t  slot_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] n_push;
  out_word_t  a, b;

  always_comb begin
    valid_o = cnt_q != 3'd0;
    pop     = valid_o && ready_i;
    word_o  = slot_q[rd_q];
    space_o = cnt_q <= 3'd2;
    a = toks_i.first;
    b = toks_i.second;
    a.last_of_run = !toks_i.second_vld;
    b.last_of_run = 1'b1;
    n_push = push_i ? 2'(toks_i.first_vld) + 2'(toks_i.second_vld) : 2'd0;
    cnt_d  = cnt_q + 3'(n_push) - 3'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (toks_i.first_vld) slot_q[wr_q] <= a;
      if (toks_i.second_vld) slot_q[wr_q + 2'(toks_i.first_vld)] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + 2'(pop);
      wr_q  <= wr_q + n_push;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("output queue overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    2'(wr_q - rd_q) == cnt_q[1:0]) else $error("queue pointers disagree with count");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o) else $error("push without room");
`endif

endmodule
`default_nettype wire
